@@ src/pba_pkg.sv @@
// Shared types, constants and helpers for the page bitmap allocator.
// No dependencies; used by pba_map_ram, pba_ctrl and page_bitmap_allocator.
package pba_pkg;

	// default geometry; PAGE_BYTES must be a power of two
	localparam int MAX_PAGES_DEF  = 4096;
	localparam int PAGE_BYTES_DEF = 4096;

	// fixed field widths of the stream items
	localparam int OP_W        = 2;
	localparam int ADDR_W      = 32;
	localparam int PAGE_ADDR_W = 24;
	localparam int CNT_OUT_W   = 13;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 56;

	// configuration registers
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_IDX_W    = 1;
	localparam int RESERVED_W   = 13;
	localparam logic [CFG_IDX_W-1:0] REG_MEMORY_BYTES   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_PAGES      = 1'd1;
	localparam logic [CFG_DATA_W-1:0] MEMORY_BYTES_RST   = 32'd16777216;
	localparam logic [RESERVED_W-1:0] LOW_PAGES_RST      = 13'd512;

	// map word geometry
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_INIT  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	// one result item
	typedef struct packed {
		logic                   ready_res;
		logic [CNT_OUT_W-1:0]   allocated_pages;
		logic [CNT_OUT_W-1:0]   free_pages;
		logic                   page_is_free;
		logic                   out_of_memory;
		logic [PAGE_ADDR_W-1:0] page_address;
	} res_t;

	// index of the lowest set bit of a map word (0 when none)
	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] bits);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (bits[b]) begin
				pos = BIT_W'(b);
			end
		end
		return pos;
	endfunction

endpackage

@@ src/page_bitmap_allocator.sv @@
// Top level of the page bitmap allocator: configuration registers, output
// register and the map memory with its sequencer. Depends on pba_pkg,
// pba_map_ram and pba_ctrl.
//
//   channel  direction  payload                                         transfer
//   s_axis   in         tdata: operation, address                       tvalid & tready
//   m_axis   out        tdata: page_address .. ready_res                tvalid & tready
//   wr_*     in         wr_index selects register, wr_data value        wr_en
//
// Free and query read the addressed map word and then check its bit; a
// misaligned or out-of-range address goes straight to the result. Allocate
// scans one map word per cycle through the memory read port until a word
// with a free bit or the last word comes back; initialise writes one word per
// cycle. One item is in work at a time; a held result does not block the next
// transfer in. The map is undefined after reset and is only read after an
// initialise; before that every other item goes straight to its result.
module page_bitmap_allocator #(
	parameter int MAX_PAGES  = pba_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [1:0] operation, [33:2] address, [39:34] zero
	input  logic [pba_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [23:0] page_address, [24] out_of_memory, [25] page_is_free,
	// [38:26] free_pages, [51:39] allocated_pages, [52] ready_res, [55:53] zero
	output logic [pba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              wr_en,
	input  logic [pba_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [pba_pkg::CFG_DATA_W-1:0]    wr_data
);

	localparam int MAP_WORDS = (MAX_PAGES + pba_pkg::WORD_BITS - 1) / pba_pkg::WORD_BITS;
	localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	logic [pba_pkg::CFG_DATA_W-1:0] memory_bytes_q;
	logic [pba_pkg::RESERVED_W-1:0] low_pages_q;
	logic                           out_valid_q;
	pba_pkg::res_t                  out_q;
	logic                           out_free;
	logic                           res_valid;
	pba_pkg::res_t                  res;
	logic                           ram_we;
	logic [WORD_AW-1:0]             ram_waddr;
	logic [pba_pkg::WORD_BITS-1:0]  ram_wdata;
	logic                           ram_re;
	logic [WORD_AW-1:0]             ram_raddr;
	logic [pba_pkg::WORD_BITS-1:0]  ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_bytes_q <= pba_pkg::MEMORY_BYTES_RST;
			low_pages_q    <= pba_pkg::LOW_PAGES_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				pba_pkg::REG_MEMORY_BYTES: memory_bytes_q <= wr_data;
				pba_pkg::REG_LOW_PAGES:    low_pages_q    <= wr_data[pba_pkg::RESERVED_W-1:0];
				default: ;
			endcase
		end
	end

	// map storage
	pba_map_ram #(
		.DEPTH (MAP_WORDS),
		.AW    (WORD_AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	pba_ctrl #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES),
		.WORD_AW    (WORD_AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_op          (pba_pkg::op_t'(s_axis_tdata[pba_pkg::OP_W-1:0])),
		.in_address     (s_axis_tdata[pba_pkg::OP_W +: pba_pkg::ADDR_W]),
		.memory_bytes   (memory_bytes_q),
		.low_pages      (low_pages_q),
		.out_free       (out_free),
		.res_valid      (res_valid),
		.res            (res),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata)
	);

	// output register
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = pba_pkg::OUT_DATA_W'(out_q);

	// one item in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second transfer taken while an item is in work");

	// a finished result never overwrites one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || m_axis_tready))
		else $error("result dropped by output register");

	// before initialise every result is zero apart from out_of_memory
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.ready_res |-> (out_q.page_address == '0)
		&& !out_q.page_is_free && (out_q.free_pages == '0) && (out_q.allocated_pages == '0))
		else $error("non-zero result before initialise");

	// an item cannot be both out of memory and a free query hit or a non-zero page address
	a_oom_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.out_of_memory && (out_q.page_is_free
		|| out_q.page_address != '0)))
		else $error("out_of_memory set together with a page result");

endmodule

@@ src/pba_map_ram.sv @@
// Page map storage: single write port, single read port, registered read data.
// Depends on pba_pkg for the word width.
module pba_map_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [pba_pkg::WORD_BITS-1:0] wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [pba_pkg::WORD_BITS-1:0] rdata
);

	logic [pba_pkg::WORD_BITS-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/pba_ctrl.sv @@
// Sequencer for the allocator: initialise sweep, free-page scan and
// read-modify-write of single map words. Depends on pba_pkg; drives pba_map_ram.
module pba_ctrl #(
	parameter int MAX_PAGES  = pba_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
	parameter int WORD_AW    = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pba_pkg::op_t                   in_op,
	input  logic [pba_pkg::ADDR_W-1:0]     in_address,
	input  logic [pba_pkg::CFG_DATA_W-1:0] memory_bytes,
	input  logic [pba_pkg::RESERVED_W-1:0] low_pages,
	input  logic                           out_free,
	output logic                           res_valid,
	output pba_pkg::res_t                  res,
	output logic                           ram_we,
	output logic [WORD_AW-1:0]             ram_waddr,
	output logic [pba_pkg::WORD_BITS-1:0]  ram_wdata,
	output logic                           ram_re,
	output logic [WORD_AW-1:0]             ram_raddr,
	input  logic [pba_pkg::WORD_BITS-1:0]  ram_rdata
);

	localparam int MAP_WORDS  = (MAX_PAGES + pba_pkg::WORD_BITS - 1) / pba_pkg::WORD_BITS;
	localparam int PTR_W      = $clog2(MAP_WORDS + 1);
	localparam int CNT_W      = $clog2(MAX_PAGES + 1);
	localparam int IDX_W      = WORD_AW + pba_pkg::BIT_W;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int LIM_W      = (CNT_W > pba_pkg::RESERVED_W) ? CNT_W : pba_pkg::RESERVED_W;
	localparam int CNT_OUT_W  = pba_pkg::CNT_OUT_W;
	localparam int PAGE_ADDR_W = pba_pkg::PAGE_ADDR_W;

	pba_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]   page_count_q;
	logic [CNT_W-1:0]   alloc_q;
	logic               ready_q;
	logic [PTR_W-1:0]   ptr_q;
	logic               rvld_q;
	logic [WORD_AW-1:0] chkw_q;
	pba_pkg::op_t       op_q;
	logic [IDX_W-1:0]   pidx_q;
	logic [PAGE_ADDR_W-1:0] res_page_q;
	logic               res_oom_q;
	logic               res_free_q;

	// accept-time decode of the byte address
	logic [pba_pkg::ADDR_W-1:0] acc_pidx;
	logic                       acc_ok;
	always_comb begin
		acc_pidx = in_address >> PAGE_SHIFT;
		acc_ok   = (in_address[PAGE_SHIFT-1:0] == '0)
		           && (acc_pidx < pba_pkg::ADDR_W'(page_count_q));
	end

	// page count from memory size, rounded up and saturated
	logic [pba_pkg::ADDR_W:0] round_sum;
	logic [pba_pkg::ADDR_W:0] round_pages;
	logic [CNT_W-1:0]         new_count;
	always_comb begin
		round_sum   = {1'b0, memory_bytes} + (pba_pkg::ADDR_W + 1)'(PAGE_BYTES - 1);
		round_pages = round_sum >> PAGE_SHIFT;
		new_count   = (round_pages > (pba_pkg::ADDR_W + 1)'(MAX_PAGES))
		              ? CNT_W'(MAX_PAGES) : CNT_W'(round_pages);
	end

	// reserved limit and the word written by the initialise sweep
	logic [LIM_W-1:0]              lim_wide;
	logic [CNT_W-1:0]              lim;
	logic [pba_pkg::WORD_BITS-1:0] init_word;
	always_comb begin
		lim_wide = (LIM_W'(low_pages) < LIM_W'(page_count_q))
		           ? LIM_W'(low_pages) : LIM_W'(page_count_q);
		lim      = CNT_W'(lim_wide);
		if (CNT_W'(ptr_q) < (lim >> pba_pkg::BIT_W)) begin
			init_word = '1;
		end else if (CNT_W'(ptr_q) == (lim >> pba_pkg::BIT_W)) begin
			init_word = ~({pba_pkg::WORD_BITS{1'b1}} << lim[pba_pkg::BIT_W-1:0]);
		end else begin
			init_word = '0;
		end
	end

	// scan of the word that came back from the map
	logic [pba_pkg::WORD_BITS-1:0]  free_bits;
	logic                           found;
	logic [pba_pkg::BIT_W-1:0]      fbit;
	logic [IDX_W-1:0]               hit_idx;
	logic                           hit_ok;
	logic                           last_word;
	logic [IDX_W+PAGE_SHIFT-1:0]    hit_addr;
	logic                           scan_rd;
	logic                           scan_hit;
	logic                           scan_end;
	always_comb begin
		free_bits = ~ram_rdata;
		found     = |free_bits;
		fbit      = pba_pkg::lowest_set(free_bits);
		hit_idx   = {chkw_q, fbit};
		hit_ok    = pba_pkg::ADDR_W'(hit_idx) < pba_pkg::ADDR_W'(page_count_q);
		last_word = (chkw_q == WORD_AW'(MAP_WORDS - 1));
		hit_addr  = {hit_idx, {PAGE_SHIFT{1'b0}}};
		scan_rd   = (ptr_q < PTR_W'(MAP_WORDS));
		scan_hit  = rvld_q && found && hit_ok;
		scan_end  = rvld_q && (found || last_word);
	end

	// bit of the addressed page in the word read back
	logic map_bit;
	assign map_bit = ram_rdata[pidx_q[pba_pkg::BIT_W-1:0]];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pba_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_op == pba_pkg::OP_INIT) begin
						state_d = pba_pkg::ST_INIT;
					end else if (!ready_q) begin
						state_d = pba_pkg::ST_DONE;
					end else if (in_op == pba_pkg::OP_ALLOC) begin
						state_d = pba_pkg::ST_SCAN;
					end else if (acc_ok) begin
						state_d = pba_pkg::ST_READ;
					end else begin
						state_d = pba_pkg::ST_DONE;
					end
				end
			end
			pba_pkg::ST_INIT: begin
				if (ptr_q == PTR_W'(MAP_WORDS - 1)) begin
					state_d = pba_pkg::ST_DONE;
				end
			end
			pba_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = pba_pkg::ST_DONE;
				end
			end
			pba_pkg::ST_READ:  state_d = pba_pkg::ST_CHECK;
			pba_pkg::ST_CHECK: state_d = pba_pkg::ST_DONE;
			pba_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pba_pkg::ST_IDLE;
				end
			end
			default: state_d = pba_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake and map port
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = chkw_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[WORD_AW-1:0];
		unique case (state_q)
			pba_pkg::ST_IDLE: in_ready = 1'b1;
			pba_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q[WORD_AW-1:0];
				ram_wdata = init_word;
			end
			pba_pkg::ST_SCAN: begin
				ram_re    = scan_rd;
				ram_we    = scan_hit;
				ram_wdata = ram_rdata | (pba_pkg::WORD_BITS'(1) << fbit);
			end
			pba_pkg::ST_READ: begin
				ram_re    = 1'b1;
				ram_raddr = pidx_q[IDX_W-1:pba_pkg::BIT_W];
			end
			pba_pkg::ST_CHECK: begin
				ram_we    = (op_q == pba_pkg::OP_FREE) && map_bit;
				ram_waddr = pidx_q[IDX_W-1:pba_pkg::BIT_W];
				ram_wdata = ram_rdata & ~(pba_pkg::WORD_BITS'(1) << pidx_q[pba_pkg::BIT_W-1:0]);
			end
			pba_pkg::ST_DONE: res_valid = out_free;
			default: ;
		endcase
	end

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pba_pkg::ST_IDLE;
			page_count_q <= '0;
			alloc_q      <= '0;
			ready_q      <= 1'b0;
			ptr_q        <= '0;
			rvld_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pba_pkg::ST_IDLE: begin
					ptr_q  <= '0;
					rvld_q <= 1'b0;
					if (in_valid && in_op == pba_pkg::OP_INIT) begin
						page_count_q <= new_count;
					end
				end
				pba_pkg::ST_INIT: begin
					ptr_q <= ptr_q + PTR_W'(1);
					if (ptr_q == PTR_W'(MAP_WORDS - 1)) begin
						alloc_q <= lim;
						ready_q <= 1'b1;
					end
				end
				pba_pkg::ST_SCAN: begin
					rvld_q <= scan_rd;
					if (scan_rd) begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
					if (scan_hit) begin
						alloc_q <= alloc_q + CNT_W'(1);
					end
				end
				pba_pkg::ST_CHECK: begin
					if (op_q == pba_pkg::OP_FREE && map_bit && alloc_q != '0) begin
						alloc_q <= alloc_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// item payload and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			pba_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q       <= in_op;
					pidx_q     <= IDX_W'(acc_pidx);
					res_page_q <= '0;
					res_oom_q  <= (in_op == pba_pkg::OP_ALLOC) && !ready_q;
					res_free_q <= 1'b0;
				end
			end
			pba_pkg::ST_SCAN: begin
				chkw_q <= ptr_q[WORD_AW-1:0];
				if (scan_hit) begin
					res_page_q <= PAGE_ADDR_W'(hit_addr);
				end else if (scan_end) begin
					res_oom_q <= 1'b1;
				end
			end
			pba_pkg::ST_CHECK: begin
				if (op_q == pba_pkg::OP_QUERY) begin
					res_free_q <= !map_bit;
				end
			end
			default: ;
		endcase
	end

	// result item as seen after this item
	always_comb begin
		res.page_address    = res_page_q;
		res.out_of_memory   = res_oom_q;
		res.page_is_free    = res_free_q;
		res.free_pages      = CNT_OUT_W'(page_count_q - alloc_q);
		res.allocated_pages = CNT_OUT_W'(alloc_q);
		res.ready_res       = ready_q;
	end

endmodule
